/* rtl/core/keypad_typematic_accel_encoder_assert.svh */
// assertion macros shared by the keypad encoder rtl
`ifndef KEYPAD_TYPEMATIC_ACCEL_ENCODER_ASSERT_SVH
`define KEYPAD_TYPEMATIC_ACCEL_ENCODER_ASSERT_SVH

// same-cycle implication
`define KTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kta_pkg.sv */
// types, codes and curve helper for the keypad encoder
package kta_pkg;

    localparam int CFG_BITS    = 10;
    localparam int KEY_BITS    = 10;
    localparam int SCORE_KEYS  = 4;
    localparam int MODE_KEYS   = 6;
    localparam int CODE_BITS   = 8;
    localparam int REPEAT_BITS = 8;
    localparam int REPEAT_MAX  = 255;

    localparam logic [CFG_BITS-1:0] SETTLE_RESET     = 10'd120;
    localparam logic [CFG_BITS-1:0] BEEP_RESET       = 10'd20;
    localparam logic [CFG_BITS-1:0] MIN_REPEAT_RESET = 10'd50;

    typedef enum logic [1:0] {
        CFG_SETTLE     = 2'd0,
        CFG_BEEP       = 2'd1,
        CFG_MIN_REPEAT = 2'd2
    } t_cfg_index;

    localparam logic [CODE_BITS-1:0] CODE_NONE    = 8'h00;
    localparam logic [CODE_BITS-1:0] CODE_RELEASE = 8'h65;
    localparam logic [CODE_BITS-1:0] SCORE_CODES [SCORE_KEYS] = '{
        8'h61, 8'h62, 8'h63, 8'h64
    };
    localparam logic [CODE_BITS-1:0] MODE_CODES [MODE_KEYS] = '{
        8'h67, 8'h68, 8'h6B, 8'h69, 8'h6A, 8'h66
    };

    typedef struct packed {
        logic [KEY_BITS-1:0] key_levels;
        logic                press_line;
    } t_tick;

    typedef struct packed {
        logic                 first_valid;
        logic [CODE_BITS-1:0] first_code;
        logic                 second_valid;
        logic [CODE_BITS-1:0] second_code;
        logic                 led_on;
        logic                 buzzer_on;
    } t_result;

    // largest d with d*d*m <= base*base, elaboration only
    function automatic int delay_curve(input int base, input int m);
        longint lo;
        longint hi;
        longint mid;
        longint b2;
        lo = 0;
        hi = longint'(base);
        b2 = longint'(base) * longint'(base);
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * longint'(m) <= b2) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return int'(lo);
    endfunction

endpackage

/* rtl/core/kta_stream_if.sv */
// valid/ready stream interface carrying one word
interface kta_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/keypad_typematic_accel_encoder.sv */
// keypad encoder with debounce, accelerating auto-repeat and beep timer
// One tick word is taken per clock cycle and its result word is registered behind the tick:
// the tick lands in an input register, and one pass of compares, priority
// encoders, a 256-entry delay ROM and the time adders updates the timing state and fills the
// result register. A stalled result register holds the tick register; ready falls only when
// both are full and the sink is not taking the result. Each tick is one millisecond of the
// internal time counter.
// Configuration writes go straight into the settle, beep and minimum repeat registers.
`include "keypad_typematic_accel_encoder_assert.svh"

module keypad_typematic_accel_encoder #(
    parameter int TIME_BITS     = 32,
    parameter int BASE_DELAY_MS = 700
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [kta_pkg::CFG_BITS-1:0]  i_cfg_data,
    kta_stream_if.sink                    i_tick,
    kta_stream_if.source                  o_result
);
    import kta_pkg::*;

    localparam int CURVE_BITS = $clog2(BASE_DELAY_MS + 1);
    localparam int DLY_BITS   = (CURVE_BITS > CFG_BITS) ? CURVE_BITS : CFG_BITS;
    localparam int ROM_DEPTH  = REPEAT_MAX + 1;

    typedef logic [DLY_BITS-1:0] t_rom [ROM_DEPTH];

    // entry per old repeat count: delay for the count after its saturating increment
    function automatic t_rom build_rom();
        t_rom rom;
        int   n;
        for (int rc = 0; rc < ROM_DEPTH; rc++) begin
            n = (rc + 1 > REPEAT_MAX) ? REPEAT_MAX : rc + 1;
            rom[rc] = DLY_BITS'(delay_curve(BASE_DELAY_MS, n + 1));
        end
        return rom;
    endfunction

    localparam t_rom DELAY_ROM = build_rom();

    logic [CFG_BITS-1:0]    r_settle;
    logic [CFG_BITS-1:0]    r_beep;
    logic [CFG_BITS-1:0]    r_min_repeat;

    logic                   r_in_valid;
    t_tick                  r_in;
    logic                   r_out_valid;
    t_result                r_out;

    logic [TIME_BITS-1:0]   r_now;
    logic [TIME_BITS-1:0]   r_due;
    logic [TIME_BITS-1:0]   r_last;
    logic [TIME_BITS-1:0]   r_beep_end;
    logic                   r_held;
    logic                   r_beeping;
    logic                   r_line;
    logic                   r_led;
    logic [REPEAT_BITS-1:0] r_rc;

    logic [TIME_BITS-1:0]   n_due;
    logic [TIME_BITS-1:0]   n_last;
    logic [TIME_BITS-1:0]   n_beep_end;
    logic                   n_held;
    logic                   n_beeping;
    logic                   n_led;
    logic [REPEAT_BITS-1:0] n_rc;
    t_result                n_out;

    logic                   advance;
    logic                   fall;
    logic                   rise;
    logic                   emit;
    logic                   score_hit;
    logic                   mode_hit;
    logic                   started;
    logic [CODE_BITS-1:0]   score_code;
    logic [CODE_BITS-1:0]   mode_code;
    logic [TIME_BITS-1:0]   gap;
    logic [DLY_BITS-1:0]    curve_dly;
    logic [DLY_BITS-1:0]    min_dly;
    logic [DLY_BITS-1:0]    dly;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    always_comb begin
        fall = (r_in.press_line != r_line) && !r_in.press_line;
        rise = (r_in.press_line != r_line) && r_in.press_line;

        n_held = fall ? 1'b1 : (rise ? 1'b0 : r_held);
        n_led  = fall ? 1'b1 : (rise ? 1'b0 : r_led);
        n_due  = fall ? r_now + TIME_BITS'(r_settle) : r_due;
        gap    = r_now - r_last;
        emit   = n_held && (r_now >= n_due) && (gap > TIME_BITS'(r_settle));

        score_hit  = 1'b0;
        score_code = CODE_NONE;
        for (int i = SCORE_KEYS - 1; i >= 0; i--) begin
            if (r_in.key_levels[i]) begin
                score_hit  = 1'b1;
                score_code = SCORE_CODES[i];
            end
        end

        mode_hit  = 1'b0;
        mode_code = CODE_NONE;
        for (int i = MODE_KEYS - 1; i >= 0; i--) begin
            if (r_in.key_levels[SCORE_KEYS + i]) begin
                mode_hit  = 1'b1;
                mode_code = MODE_CODES[i];
            end
        end
        mode_hit = mode_hit && (r_rc == '0);

        curve_dly = DELAY_ROM[r_rc];
        min_dly   = DLY_BITS'(r_min_repeat);
        dly       = (curve_dly >= min_dly) ? curve_dly : min_dly;

        n_last = r_last;
        n_rc   = rise ? '0 : r_rc;
        if (emit) begin
            n_last = n_due;
            n_due  = r_now + TIME_BITS'(dly);
            if (r_rc != REPEAT_BITS'(REPEAT_MAX)) begin
                n_rc = r_rc + REPEAT_BITS'(1);
            end
        end

        started    = emit && (score_hit || mode_hit);
        n_beep_end = started ? r_now + TIME_BITS'(r_beep) : r_beep_end;
        n_beeping  = (started || r_beeping) && !(r_now >= n_beep_end);

        n_out.first_valid  = rise || (emit && score_hit);
        n_out.first_code   = rise ? CODE_RELEASE : ((emit && score_hit) ? score_code : CODE_NONE);
        n_out.second_valid = emit && mode_hit;
        n_out.second_code  = (emit && mode_hit) ? mode_code : CODE_NONE;
        n_out.led_on       = n_led;
        n_out.buzzer_on    = n_beeping;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle     <= SETTLE_RESET;
            r_beep       <= BEEP_RESET;
            r_min_repeat <= MIN_REPEAT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SETTLE:     r_settle     <= i_cfg_data;
                CFG_BEEP:       r_beep       <= i_cfg_data;
                CFG_MIN_REPEAT: r_min_repeat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.valid && i_tick.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in <= i_tick.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_due      <= '0;
            r_last     <= '0;
            r_beep_end <= '0;
            r_held     <= 1'b0;
            r_beeping  <= 1'b0;
            r_line     <= 1'b1;
            r_led      <= 1'b0;
            r_rc       <= '0;
        end else if (advance) begin
            r_now      <= r_now + TIME_BITS'(1);
            r_due      <= n_due;
            r_last     <= n_last;
            r_beep_end <= n_beep_end;
            r_held     <= n_held;
            r_beeping  <= n_beeping;
            r_line     <= r_in.press_line;
            r_led      <= n_led;
            r_rc       <= n_rc;
        end
    end

    `KTA_ASSERT_NEXT(a_tick_captured, i_clk, i_rst_n, i_tick.valid && i_tick.ready,
        r_in_valid, "accepted tick word not held in input register")
    `KTA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !o_result.ready,
        r_out_valid && $stable(r_out), "stalled result word changed")
    `KTA_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, advance && rise,
        r_rc == '0 && !r_held && !r_led, "release did not clear press state")
    `KTA_ASSERT_NEXT(a_mode_first_only, i_clk, i_rst_n, advance && n_out.second_valid,
        r_rc == REPEAT_BITS'(1), "mode code emitted outside first repeat")
    `KTA_ASSERT_NOW(a_led_tracks_hold, i_clk, i_rst_n, 1'b1,
        r_led == r_held, "led level differs from hold state")

endmodule
